[src/njs_pkg.sv]
// Shared types, constants and key selection for the job scheduler.
`timescale 1ns / 1ps

package njs_pkg;

  localparam int MaxJobs = 16;
  localparam int IdxW    = $clog2(MaxJobs);
  localparam int CountW  = $clog2(MaxJobs + 1);
  localparam int TimeW   = 21;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic [1:0] ModeFcfs = 2'd0;
  localparam logic [1:0] ModeSjf  = 2'd1;
  localparam logic [1:0] ModePrio = 2'd2;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arr;
    logic [15:0] bst;
    logic [7:0]  pri;
  } job_rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic pick;
    logic tat;
    logic emit;
    logic clear;
  } njs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic pick_last;
  } njs_status_t;

  function automatic logic [15:0] key_of(input logic [1:0] mode, input job_rec_t rec);
    logic [15:0] key;
    case (mode)
      ModeFcfs: key = rec.arr;
      ModeSjf:  key = rec.bst;
      ModePrio: key = {8'd0, rec.pri};
      default:  key = rec.arr;
    endcase
    return key;
  endfunction

endpackage

[src/nonpreemptive_job_scheduler_top.sv]
// Top level of the non-preemptive job scheduler.
`timescale 1ns / 1ps

// Usage:
//   Jobs are loaded one request at a time: a request is taken at a rising edge
//   with start_i high and busy_o low. Loading a job gives
//   no result. Jobs beyond 16 in a set are dropped. The request with
//   final_job_i set stores its job and starts scheduling the set.
//   mode_we_i/mode_wdata_i write the mode (0 FCFS, 1 shortest burst,
//   2 priority); write it only while busy_o is low; the block does not enforce it.
//   For each pick the controller scans the table one entry at a time, then
//   steps through the pick, turnaround and emit states; the pace is set by
//   the sequential table scan.
//   Each result is shown on the result ports for one cycle with out_valid_o
//   high; run_end_o marks the last. The receiver cannot stall.
//   Reset clears the job count, scheduled mask, clock and mode to zero.
module nonpreemptive_job_scheduler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  job_id_i,
  input  logic [15:0] arrival_i,
  input  logic [15:0] burst_i,
  input  logic [7:0]  prio_i,
  input  logic        final_job_i,
  input  logic        mode_we_i,
  input  logic [1:0]  mode_wdata_i,
  output logic        out_valid_o,
  output logic [7:0]  out_id_o,
  output logic [20:0] completion_o,
  output logic [20:0] turnaround_o,
  output logic [20:0] waiting_o,
  output logic        run_end_o
);
  import njs_pkg::*;

  njs_cmd_t    cmd;
  njs_status_t status;
  job_rec_t    rec;

  assign rec.id  = job_id_i;
  assign rec.arr = arrival_i;
  assign rec.bst = burst_i;
  assign rec.pri = prio_i;

  njs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .final_job_i (final_job_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy_o)
  );

  njs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .mode_we_i    (mode_we_i),
    .mode_wdata_i (mode_wdata_i),
    .rec_i        (rec),
    .out_valid_o  (out_valid_o),
    .out_id_o     (out_id_o),
    .completion_o (completion_o),
    .turnaround_o (turnaround_o),
    .waiting_o    (waiting_o),
    .run_end_o    (run_end_o)
  );

`ifndef ASSERT_OFF
  a_final_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && final_job_i) |=> busy_o)
    else $error("final request did not start scheduling");

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobes back to back");

  a_wait_le_tat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (waiting_o <= turnaround_o))
    else $error("waiting exceeds turnaround");

  a_tat_le_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (turnaround_o <= completion_o))
    else $error("turnaround exceeds completion");
`endif

endmodule

[src/njs_ctrl.sv]
// Controller state machine: load, scan, pick, timing and emit sequencing.
`timescale 1ns / 1ps

module njs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                final_job_i,
  input  njs_pkg::njs_status_t status_i,
  output njs_pkg::njs_cmd_t    cmd_o,
  output logic                busy_o
);
  import njs_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StPick = 3'd2;
  localparam logic [2:0] StTat  = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (final_job_i) begin
            cmd_o.scan_init = 1'b1;
            state_d         = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) state_d = StPick;
      end
      StPick: begin
        cmd_o.pick = 1'b1;
        state_d    = StTat;
      end
      StTat: begin
        cmd_o.tat = 1'b1;
        state_d   = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (status_i.pick_last) begin
          cmd_o.clear = 1'b1;
          state_d     = StIdle;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = StScan;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

[src/njs_datapath.sv]
// Datapath: job table, selection scan, scheduling clock and result registers.
`timescale 1ns / 1ps

module njs_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  njs_pkg::njs_cmd_t    cmd_i,
  output njs_pkg::njs_status_t status_o,
  input  logic                 mode_we_i,
  input  logic [1:0]           mode_wdata_i,
  input  njs_pkg::job_rec_t    rec_i,
  output logic                 out_valid_o,
  output logic [7:0]           out_id_o,
  output logic [njs_pkg::TimeW-1:0] completion_o,
  output logic [njs_pkg::TimeW-1:0] turnaround_o,
  output logic [njs_pkg::TimeW-1:0] waiting_o,
  output logic                 run_end_o
);
  import njs_pkg::*;

  job_rec_t             table_q [MaxJobs];
  logic [MaxJobs-1:0]   done_q;
  logic [CountW-1:0]    count_q;
  logic [CountW-1:0]    picks_q;
  logic [TimeW-1:0]     now_q;
  logic [IdxW-1:0]      idx_q;
  logic [1:0]           mode_q;
  logic                 rfound_q, efound_q;
  job_rec_t             rrec_q, erec_q, cur_q;
  logic [15:0]          rkey_q, ekey_q;
  logic [IdxW-1:0]      ridx_q, eidx_q;
  logic [TimeW-1:0]     comp_q, tat_q;
  logic                 valid_q;

  job_rec_t         ent;
  logic             pend, ready, r_take, e_take;
  logic [15:0]      kc;
  job_rec_t         sel_rec;
  logic [IdxW-1:0]  sel_idx;
  logic [TimeW-1:0] start_t, comp;
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] bst_ext, wt;
  logic             pick_last;

  assign ent   = table_q[idx_q];
  assign pend  = !done_q[idx_q];
  assign kc    = key_of(mode_q, ent);
  assign ready = pend && ({5'd0, ent.arr} <= now_q);
  // Ready set: best key, ties to earlier arrival, then lower index.
  assign r_take = ready && (!rfound_q || (kc < rkey_q) ||
                  ((kc == rkey_q) && (ent.arr < rrec_q.arr)));
  // Earliest arrivals: lowest arrival, then best key, then lower index.
  assign e_take = pend && (!efound_q || (ent.arr < erec_q.arr) ||
                  ((ent.arr == erec_q.arr) && (kc < ekey_q)));

  assign sel_rec = rfound_q ? rrec_q : erec_q;
  assign sel_idx = rfound_q ? ridx_q : eidx_q;
  assign start_t = rfound_q ? now_q : {5'd0, erec_q.arr};
  assign sum     = {1'b0, start_t} + {6'd0, sel_rec.bst};
  assign comp    = sum[TimeW] ? TimeMax : sum[TimeW-1:0];

  assign bst_ext = {5'd0, cur_q.bst};
  assign wt      = (tat_q >= bst_ext) ? (tat_q - bst_ext) : '0;

  assign pick_last          = (picks_q == (count_q - CountW'(1)));
  assign status_o.pick_last = pick_last;
  assign status_o.scan_last = ({1'b0, idx_q} == (count_q - CountW'(1)));

  // Job table: no reset, only loaded entries are ever scanned.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CountW'(MaxJobs))) begin
      table_q[count_q[IdxW-1:0]] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= '0;
      count_q  <= '0;
      picks_q  <= '0;
      now_q    <= '0;
      idx_q    <= '0;
      mode_q   <= ModeFcfs;
      rfound_q <= 1'b0;
      efound_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (mode_we_i) mode_q <= mode_wdata_i;
      if (cmd_i.load && (count_q < CountW'(MaxJobs))) count_q <= count_q + CountW'(1);
      if (cmd_i.scan_init) begin
        idx_q    <= '0;
        rfound_q <= 1'b0;
        efound_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + IdxW'(1);
        if (r_take) rfound_q <= 1'b1;
        if (e_take) efound_q <= 1'b1;
      end
      if (cmd_i.pick) begin
        now_q           <= comp;
        done_q[sel_idx] <= 1'b1;
      end
      if (cmd_i.emit && !cmd_i.clear) picks_q <= picks_q + CountW'(1);
      if (cmd_i.clear) begin
        done_q  <= '0;
        count_q <= '0;
        picks_q <= '0;
        now_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && r_take) begin
      rrec_q <= ent;
      rkey_q <= kc;
      ridx_q <= idx_q;
    end
    if (cmd_i.scan_step && e_take) begin
      erec_q <= ent;
      ekey_q <= kc;
      eidx_q <= idx_q;
    end
    if (cmd_i.pick) begin
      cur_q  <= sel_rec;
      comp_q <= comp;
    end
    if (cmd_i.tat) tat_q <= comp_q - {5'd0, cur_q.arr};
    if (cmd_i.emit) begin
      out_id_o     <= cur_q.id;
      completion_o <= comp_q;
      turnaround_o <= tat_q;
      waiting_o    <= wt;
      run_end_o    <= pick_last;
    end
  end

  assign out_valid_o = valid_q;

endmodule

[tb/tb_nonpreemptive_job_scheduler_top.sv]
// Testbench for the job scheduler: job set requests with a scoreboard of expected runs.
`timescale 1ns / 1ps

module tb_nonpreemptive_job_scheduler_top;
  import njs_pkg::*;

  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomItems   = 220;

  typedef enum int {
    ProfileDense,
    ProfileFull,
    ProfileLate
  } job_profile_e;

  typedef struct {
    logic [7:0]  id;
    logic [20:0] completion;
    logic [20:0] turnaround;
    logic [20:0] wtime;
    logic        last;
  } run_result_t;

  // Keeps its own copy of the job table and mode, and predicts the run order.
  class sched_scoreboard;
    job_rec_t    jobs[MaxJobs];
    int unsigned stored;
    logic [1:0]  mode;
    run_result_t expected_runs[$];
    int unsigned errors;

    function new();
      stored = 0;
      mode   = ModeFcfs;
      errors = 0;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
    endfunction

    function int unsigned pending();
      return expected_runs.size();
    endfunction

    function int unsigned sort_key(job_rec_t j);
      int unsigned k;
      case (mode)
        ModeSjf:  k = 32'(j.bst);
        ModePrio: k = 32'(j.pri);
        default:  k = 32'(j.arr);
      endcase
      return k;
    endfunction

    function void plan_runs();
      bit [MaxJobs-1:0] done;
      int unsigned      now, earliest, comp, tat, wt, best;
      bit               any_ready, found;
      run_result_t      r;
      done = '0;
      now  = 0;
      for (int k = 0; k < stored; k++) begin
        any_ready = 0;
        found     = 0;
        earliest  = 0;
        for (int i = 0; i < stored; i++) begin
          if (!done[i]) begin
            if (32'(jobs[i].arr) <= now) any_ready = 1;
            if (!found || 32'(jobs[i].arr) < earliest) begin
              earliest = 32'(jobs[i].arr);
              found    = 1;
            end
          end
        end
        // idle CPU: jump to the next arrival
        if (!any_ready) now = earliest;
        found = 0;
        best  = 0;
        for (int i = 0; i < stored; i++) begin
          if (!done[i] && 32'(jobs[i].arr) <= now) begin
            if (!found) begin
              best  = i;
              found = 1;
            end else if (sort_key(jobs[i]) < sort_key(jobs[best]) ||
                         (sort_key(jobs[i]) == sort_key(jobs[best]) &&
                          jobs[i].arr < jobs[best].arr)) begin
              best = i;
            end
          end
        end
        comp = now + 32'(jobs[best].bst);
        if (comp > 32'(TimeMax)) comp = 32'(TimeMax);
        now        = comp;
        done[best] = 1;
        tat        = comp - 32'(jobs[best].arr);
        wt         = (tat >= 32'(jobs[best].bst)) ? tat - 32'(jobs[best].bst) : 0;
        r.id         = jobs[best].id;
        r.completion = 21'(comp);
        r.turnaround = 21'(tat);
        r.wtime      = 21'(wt);
        r.last       = (k == stored - 1);
        expected_runs.push_back(r);
      end
      stored = 0;
    endfunction

    function void note_request(job_rec_t j, bit last);
      // table full: job is dropped, the final mark still counts
      if (stored < MaxJobs) begin
        jobs[stored] = j;
        stored++;
      end
      if (last) plan_runs();
    endfunction

    function void compare_field(string label, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s expected %0d actual %0d", $time, label, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [7:0] id, logic [20:0] comp, logic [20:0] tat,
                               logic [20:0] wt, logic last);
      run_result_t e;
      if (expected_runs.size() == 0) begin
        $display("%0t: unexpected result id %0d completion %0d", $time, id, comp);
        errors++;
        return;
      end
      e = expected_runs.pop_front();
      compare_field("out_id", 32'(e.id), 32'(id));
      compare_field("completion", 32'(e.completion), 32'(comp));
      compare_field("turnaround", 32'(e.turnaround), 32'(tat));
      compare_field("waiting", 32'(e.wtime), 32'(wt));
      compare_field("run_end", 32'(e.last), 32'(last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [7:0]  job_id_i;
  logic [15:0] arrival_i;
  logic [15:0] burst_i;
  logic [7:0]  prio_i;
  logic        final_job_i;
  logic        mode_we_i;
  logic [1:0]  mode_wdata_i;
  logic        out_valid_o;
  logic [7:0]  out_id_o;
  logic [20:0] completion_o;
  logic [20:0] turnaround_o;
  logic [20:0] waiting_o;
  logic        run_end_o;

  sched_scoreboard sb = new();
  int unsigned     jobs_sent = 0;
  int unsigned     idle_cycles = 0;

  nonpreemptive_job_scheduler_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .job_id_i     (job_id_i),
    .arrival_i    (arrival_i),
    .burst_i      (burst_i),
    .prio_i       (prio_i),
    .final_job_i  (final_job_i),
    .mode_we_i    (mode_we_i),
    .mode_wdata_i (mode_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_id_o     (out_id_o),
    .completion_o (completion_o),
    .turnaround_o (turnaround_o),
    .waiting_o    (waiting_o),
    .run_end_o    (run_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      sb.check_result(out_id_o, completion_o, turnaround_o, waiting_o, run_end_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || out_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("nonpreemptive_job_scheduler_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic job_rec_t mk_job(int unsigned id, int unsigned arr, int unsigned bst,
                                      int unsigned pri);
    job_rec_t j;
    j.id  = 8'(id);
    j.arr = 16'(arr);
    j.bst = 16'(bst);
    j.pri = 8'(pri);
    return j;
  endfunction

  task automatic send_job(job_rec_t j, bit last, int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i     <= 1'b1;
    job_id_i    <= j.id;
    arrival_i   <= j.arr;
    burst_i     <= j.bst;
    prio_i      <= j.pri;
    final_job_i <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(j, last);
    jobs_sent++;
  endtask

  // Wait until every expected run has been seen and the block is idle.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [1:0] m);
    drain();
    @(negedge clk_i);
    mode_we_i    <= 1'b1;
    mode_wdata_i <= m;
    sb.set_mode(m);
    @(negedge clk_i);
    mode_we_i <= 1'b0;
  endtask

  task automatic run_random_set(int unsigned n, job_profile_e profile, bit no_gaps);
    job_rec_t j;
    for (int i = 0; i < n; i++) begin
      j.id = 8'($urandom_range(0, 255));
      case (profile)
        ProfileDense: begin
          j.arr = 16'($urandom_range(0, 40));
          j.bst = 16'($urandom_range(0, 12));
          j.pri = 8'($urandom_range(0, 5));
        end
        ProfileLate: begin
          j.arr = 16'($urandom_range(65500, 65535));
          j.bst = 16'($urandom_range(0, 65535));
          j.pri = 8'($urandom_range(250, 255));
        end
        default: begin
          j.arr = 16'($urandom);
          j.bst = 16'($urandom);
          j.pri = 8'($urandom);
        end
      endcase
      send_job(j, i == n - 1, no_gaps ? 0 : $urandom_range(0, 16));
    end
  endtask

  initial begin
    int unsigned  set_size;
    int unsigned  pick;
    job_profile_e profile;

    rst_ni       = 1'b0;
    start_i      = 1'b0;
    job_id_i     = '0;
    arrival_i    = '0;
    burst_i      = '0;
    prio_i       = '0;
    final_job_i  = 1'b0;
    mode_we_i    = 1'b0;
    mode_wdata_i = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset mode is FCFS; all-ones job waits for its arrival, then all-zero job
    send_job(mk_job(255, 65535, 65535, 255), 1'b1, 0);
    send_job(mk_job(0, 0, 0, 0), 1'b1, 3);

    // shortest burst: equal keys and arrivals fall to load order, late job idles CPU
    write_mode(ModeSjf);
    send_job(mk_job(1, 5, 9, 3), 1'b0, 0);
    send_job(mk_job(2, 0, 4, 1), 1'b0, 0);
    send_job(mk_job(3, 0, 4, 7), 1'b0, 2);
    send_job(mk_job(4, 100, 1, 0), 1'b1, 0);

    write_mode(ModePrio);
    send_job(mk_job(5, 2, 3, 9), 1'b0, 1);
    send_job(mk_job(6, 0, 10, 9), 1'b0, 0);
    send_job(mk_job(7, 1, 2, 0), 1'b0, 0);
    send_job(mk_job(8, 3, 0, 9), 1'b1, 5);

    // unused mode code behaves as FCFS
    write_mode(2'd3);
    send_job(mk_job(9, 30, 5, 0), 1'b0, 0);
    send_job(mk_job(10, 10, 5, 1), 1'b0, 0);
    send_job(mk_job(11, 10, 2, 2), 1'b1, 0);

    write_mode(ModeFcfs);
    send_job(mk_job(12, 7, 3, 0), 1'b0, 0);
    send_job(mk_job(13, 7, 1, 0), 1'b1, 0);

    pick = jobs_sent + RandomItems;
    while (jobs_sent < pick) begin
      if ($urandom_range(0, 2) == 0) write_mode(2'($urandom_range(0, 3)));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: set_size = $urandom_range(1, 6);
        6, 7, 8:          set_size = $urandom_range(7, 16);
        default:          set_size = $urandom_range(17, 20);  // overflows the table
      endcase
      case ($urandom_range(0, 4))
        0, 1, 2: profile = ProfileDense;
        3:       profile = ProfileFull;
        default: profile = ProfileLate;
      endcase
      run_random_set(set_size, profile, $urandom_range(0, 9) < 3);
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("nonpreemptive_job_scheduler_top: match");
    end else begin
      $display("nonpreemptive_job_scheduler_top: mismatch");
    end
    $finish;
  end

endmodule

[nonpreemptive_job_scheduler_top.f]
src/njs_pkg.sv
src/njs_ctrl.sv
src/njs_datapath.sv
src/nonpreemptive_job_scheduler_top.sv
tb/tb_nonpreemptive_job_scheduler_top.sv
